// ----- src/mpfbt_pkg.sv -----
// ----------------------------------------------------------------------------
// mpfbt_pkg: shared definitions of the MAC-pair flow byte table
// Widths, status codes and the structs passed between the top level and
// the cells of the entry chain.
// ----------------------------------------------------------------------------
package mpfbt_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 32;
	localparam int OCC_W         = $clog2(TABLE_ENTRIES + 1);

	// field widths
	localparam int MAC_W    = 48;
	localparam int VER_W    = 4;
	localparam int BYTES_W  = 16;
	localparam int CTR_W    = 64;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 6;

	// ip version that counts as ipv4
	localparam logic [VER_W-1:0] IPV4_VERSION = VER_W'(4);

	// item functions
	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUMP_ENTRY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DUMP_EMPTY = 3'd4;

	// one table entry as held in a cell
	typedef struct packed {
		logic [MAC_W-1:0] src;
		logic [MAC_W-1:0] dst;
		logic [CTR_W-1:0] c4;
		logic [CTR_W-1:0] c6;
	} entry_t;

	// sample broadcast to every cell
	typedef struct packed {
		logic [MAC_W-1:0]   src;
		logic [MAC_W-1:0]   dst;
		logic               is4;
		logic [BYTES_W-1:0] nbytes;
	} sample_t;

	// per-cell control
	typedef struct packed {
		logic upd;
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

// ----- src/mpfbt_in_if.sv -----
// ----------------------------------------------------------------------------
// mpfbt_in_if: input channel of the flow table
// Valid/ready channel carrying one add or flush item.
// ----------------------------------------------------------------------------
interface mpfbt_in_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [mpfbt_pkg::MAC_W-1:0]   src_mac;
	logic [mpfbt_pkg::MAC_W-1:0]   dst_mac;
	logic [mpfbt_pkg::VER_W-1:0]   ip_version;
	logic [mpfbt_pkg::BYTES_W-1:0] byte_count;

	modport source (output valid, func, src_mac, dst_mac, ip_version, byte_count,
		input ready);
	modport sink (input valid, func, src_mac, dst_mac, ip_version, byte_count,
		output ready);
endinterface

// ----- src/mpfbt_out_if.sv -----
// ----------------------------------------------------------------------------
// mpfbt_out_if: result channel of the flow table
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface mpfbt_out_if;
	logic                           valid;
	logic                           ready;
	logic [mpfbt_pkg::STATUS_W-1:0] status;
	logic [mpfbt_pkg::MAC_W-1:0]    entry_src_mac;
	logic [mpfbt_pkg::MAC_W-1:0]    entry_dst_mac;
	logic [mpfbt_pkg::CTR_W-1:0]    ipv4_bytes;
	logic [mpfbt_pkg::CTR_W-1:0]    ipv6_bytes;
	logic [mpfbt_pkg::CNT_W-1:0]    entries_used;
	logic                           last;

	modport source (output valid, status, entry_src_mac, entry_dst_mac, ipv4_bytes,
		ipv6_bytes, entries_used, last, input ready);
	modport sink (input valid, status, entry_src_mac, entry_dst_mac, ipv4_bytes,
		ipv6_bytes, entries_used, last, output ready);
endinterface

// ----- src/mac_pair_flow_byte_table.sv -----
// Add item: accepted in idle, compared in the cell row in the match state, where
// the hit vector is registered, and its result goes to the output register in
// the apply state; no new item is taken until the apply state returns to idle.
// Flush item: one result per cycle while the result channel is free, as the
// chain shifts towards cell zero; the next item is taken once the last entry, or
// the empty-table result, is loaded into the output register. Result stalls hold both.
// Reset clears the entry count, the controller, the dump countdown and the output valid only.
// ----------------------------------------------------------------------------
// mac_pair_flow_byte_table: flow byte accounting keyed by a MAC pair
// Row of entry cells with a small controller, an item register and an
// output register between the item and result channels.
// ----------------------------------------------------------------------------
module mac_pair_flow_byte_table (
	input  logic        clk,
	input  logic        arst_n,
	mpfbt_in_if.sink    req,
	mpfbt_out_if.source rsp
);

	localparam int N = mpfbt_pkg::TABLE_ENTRIES;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_MATCH = 4'b0010,
		S_APPLY = 4'b0100,
		S_DUMP  = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [mpfbt_pkg::OCC_W-1:0]   occ_q;
	logic [mpfbt_pkg::OCC_W-1:0]   rem_q;
	mpfbt_pkg::sample_t            smp_q;
	logic [N-1:0]                  match_q;

	mpfbt_pkg::entry_t             cell_entry [N];
	logic [N-1:0]                  cell_match;
	mpfbt_pkg::cell_ctl_t          cell_ctl [N];

	logic                          out_valid_q;
	logic [mpfbt_pkg::STATUS_W-1:0] out_status_q;
	logic [mpfbt_pkg::MAC_W-1:0]   out_src_q;
	logic [mpfbt_pkg::MAC_W-1:0]   out_dst_q;
	logic [mpfbt_pkg::CTR_W-1:0]   out_c4_q;
	logic [mpfbt_pkg::CTR_W-1:0]   out_c6_q;
	logic [mpfbt_pkg::CNT_W-1:0]   out_used_q;
	logic                          out_last_q;

	logic                          take;
	logic                          out_free;
	logic                          apply_go;
	logic                          dump_go;
	logic                          hit;
	logic                          room;

	// handshake and step enables
	assign req.ready = (state_q == S_IDLE);
	assign take      = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign apply_go  = (state_q == S_APPLY) && out_free;
	assign dump_go   = (state_q == S_DUMP) && out_free && (rem_q != '0);
	assign hit       = |match_q;
	assign room      = occ_q < mpfbt_pkg::OCC_W'(N);

	// row of entry cells, each shifting from its upper neighbour
	for (genvar k = 0; k < N; k++) begin : g_cell
		always_comb begin
			cell_ctl[k].upd   = apply_go && match_q[k];
			cell_ctl[k].load  = apply_go && !hit && room &&
				(occ_q == mpfbt_pkg::OCC_W'(k));
			cell_ctl[k].shift = dump_go;
		end

		mpfbt_cell u_cell (
			.clk   (clk),
			.ctl   (cell_ctl[k]),
			.smp   (smp_q),
			.nbr   (cell_entry[(k + 1 < N) ? k + 1 : k]),
			.entry (cell_entry[k]),
			.match (cell_match[k])
		);
	end

	// sample register and registered hit vector, masked by the count
	always_ff @(posedge clk) begin
		if (take) begin
			smp_q.src    <= req.src_mac;
			smp_q.dst    <= req.dst_mac;
			smp_q.is4    <= (req.ip_version == mpfbt_pkg::IPV4_VERSION);
			smp_q.nbytes <= req.byte_count;
		end
		if (state_q == S_MATCH) begin
			for (int k = 0; k < N; k++) begin
				match_q[k] <= cell_match[k] && (mpfbt_pkg::OCC_W'(k) < occ_q);
			end
		end
	end

	// controller, entry count and dump countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (req.func == mpfbt_pkg::FUNC_FLUSH) begin
							rem_q   <= occ_q;
							state_q <= S_DUMP;
						end else begin
							state_q <= S_MATCH;
						end
					end
				end
				S_MATCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (out_free) begin
						if (!hit && room) begin
							occ_q <= mpfbt_pkg::OCC_W'(occ_q + 1'b1);
						end
						state_q <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (out_free) begin
						if (rem_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							rem_q <= mpfbt_pkg::OCC_W'(rem_q - 1'b1);
							if (rem_q == mpfbt_pkg::OCC_W'(1)) begin
								occ_q   <= '0;
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_go || ((state_q == S_DUMP) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (apply_go) begin
			out_src_q  <= '0;
			out_dst_q  <= '0;
			out_c4_q   <= '0;
			out_c6_q   <= '0;
			out_last_q <= 1'b1;
			if (hit) begin
				out_status_q <= mpfbt_pkg::ST_UPDATED;
				out_used_q   <= mpfbt_pkg::CNT_W'(occ_q);
			end else if (room) begin
				out_status_q <= mpfbt_pkg::ST_INSERTED;
				out_used_q   <= mpfbt_pkg::CNT_W'(occ_q + 1'b1);
			end else begin
				out_status_q <= mpfbt_pkg::ST_DROPPED;
				out_used_q   <= mpfbt_pkg::CNT_W'(occ_q);
			end
		end else if ((state_q == S_DUMP) && out_free) begin
			out_used_q <= mpfbt_pkg::CNT_W'(occ_q);
			if (rem_q == '0) begin
				// flush of an empty table
				out_status_q <= mpfbt_pkg::ST_DUMP_EMPTY;
				out_src_q    <= '0;
				out_dst_q    <= '0;
				out_c4_q     <= '0;
				out_c6_q     <= '0;
				out_last_q   <= 1'b1;
			end else begin
				out_status_q <= mpfbt_pkg::ST_DUMP_ENTRY;
				out_src_q    <= cell_entry[0].src;
				out_dst_q    <= cell_entry[0].dst;
				out_c4_q     <= cell_entry[0].c4;
				out_c6_q     <= cell_entry[0].c6;
				out_last_q   <= (rem_q == mpfbt_pkg::OCC_W'(1));
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.entry_src_mac = out_src_q;
	assign rsp.entry_dst_mac = out_dst_q;
	assign rsp.ipv4_bytes    = out_c4_q;
	assign rsp.ipv6_bytes    = out_c6_q;
	assign rsp.entries_used  = out_used_q;
	assign rsp.last          = out_last_q;

endmodule

// ----- src/mpfbt_cell.sv -----
// ----------------------------------------------------------------------------
// mpfbt_cell: one entry of the flow table chain
// Holds a key pair and two byte counters, compares its key with the
// broadcast sample, adds on a hit, loads on insert and takes its upper
// neighbour's entry when the chain shifts during a dump.
// ----------------------------------------------------------------------------
module mpfbt_cell (
	input  logic                 clk,
	input  mpfbt_pkg::cell_ctl_t ctl,
	input  mpfbt_pkg::sample_t   smp,
	input  mpfbt_pkg::entry_t    nbr,
	output mpfbt_pkg::entry_t    entry,
	output logic                 match
);

	mpfbt_pkg::entry_t entry_q;

	// key compare against the broadcast sample
	assign match = (entry_q.src == smp.src) && (entry_q.dst == smp.dst);
	assign entry = entry_q;

	// update, insert or shift
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= nbr;
		end else if (ctl.load) begin
			entry_q.src <= smp.src;
			entry_q.dst <= smp.dst;
			entry_q.c4  <= smp.is4 ? mpfbt_pkg::CTR_W'(smp.nbytes) : '0;
			entry_q.c6  <= smp.is4 ? '0 : mpfbt_pkg::CTR_W'(smp.nbytes);
		end else if (ctl.upd) begin
			if (smp.is4) begin
				entry_q.c4 <= entry_q.c4 + mpfbt_pkg::CTR_W'(smp.nbytes);
			end else begin
				entry_q.c6 <= entry_q.c6 + mpfbt_pkg::CTR_W'(smp.nbytes);
			end
		end
	end

endmodule
